// ===== hw/rtl/lmls_pkg.sv =====
// ----------------------------------------------------------------------------
// lmls_pkg
// Types and constants shared by the LCD mode/line sequencer modules.
// ----------------------------------------------------------------------------
package lmls_pkg;

	localparam int unsigned DOT_W = 10;
	localparam int unsigned LINE_W = 8;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_LCD_ENABLE   = 2'd0,
		REG_STAT_ENABLES = 2'd1,
		REG_LINE_COMPARE = 2'd2,
		REG_DOUBLE_SPEED = 2'd3
	} reg_idx_t;

	// mode lengths in dots, single speed
	localparam logic [DOT_W-1:0] DOTS_HBLANK = 10'd204;
	localparam logic [DOT_W-1:0] DOTS_VBLANK = 10'd456;
	localparam logic [DOT_W-1:0] DOTS_OAM    = 10'd80;
	localparam logic [DOT_W-1:0] DOTS_DRAW   = 10'd172;

	localparam logic [LINE_W-1:0] LAST_DRAWN_LINE  = 8'd143;
	localparam logic [LINE_W-1:0] VBLANK_WRAP_LINE = 8'd153;
	localparam logic [LINE_W-1:0] RESET_LINE       = 8'h91;
	localparam logic [DOT_W-1:0]  RESET_DOTS       = 10'd200;

	// STAT enable bits
	localparam int unsigned STAT_HBLANK = 0;
	localparam int unsigned STAT_VBLANK = 1;
	localparam int unsigned STAT_OAM    = 2;
	localparam int unsigned STAT_LYC    = 3;

	typedef struct packed {
		logic             mode_end;
		logic [DOT_W-1:0] dots;
	} dot_res_t;

endpackage

// ===== hw/rtl/lcd_mode_line_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_mode_line_sequencer
// LCD mode and line sequencer: while the LCD is enabled, advances the dots by the
// clocks of each transaction rounded down to a multiple of 4, and reports mode, line and the interrupts raised.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  s_axis    | in  | tdata[5:0] clocks
//  m_axis    | out | tdata mode, line, vblank_irq, stat_irq, line_drawn
//  cfg       | in  | cfg_addr register index, cfg_wdata value
//
//  After acceptance a transaction runs its ticks through the shared dot unit,
//  then loads the output register and returns to idle; the next transaction
//  can be accepted only once the block is idle again.
//  s_tready is high only while idle; a held result stalls the block in its
//  final cycle until the output register frees up.
//  Reset: mode VBlank, line 145, dot count 200, no pending compare.
// ----------------------------------------------------------------------------
module lcd_mode_line_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [5:0] clocks, [7:6] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [1:0] mode, [9:2] line, [10] vblank_irq,
	                                // [11] stat_irq, [12] line_drawn, [15:13] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;

	logic                        lcd_enable_q;
	logic [3:0]                  stat_en_q;
	logic [lmls_pkg::LINE_W-1:0] line_compare_q;
	logic                        double_speed_q;

	lmls_pkg::mode_t             mode_q;
	logic [lmls_pkg::LINE_W-1:0] line_q;
	logic [lmls_pkg::DOT_W-1:0]  dots_q;
	logic                        pending_q;
	logic [3:0]                  ticks_q;
	logic                        vbl_acc_q;
	logic                        stat_acc_q;
	logic                        drawn_acc_q;

	logic        out_valid_q;
	logic [15:0] out_data_q;

	lmls_pkg::dot_res_t dres;

	lmls_dot_unit u_dot (
		.dots         (dots_q),
		.mode         (mode_q),
		.double_speed (double_speed_q),
		.res          (dres)
	);

	// next-state of one tick
	lmls_pkg::mode_t             mode_n;
	logic [lmls_pkg::LINE_W-1:0] line_n;
	logic [lmls_pkg::LINE_W-1:0] line_inc;
	logic                        line_chg;
	logic                        vbl_t;
	logic                        stat_t;
	logic                        drawn_t;
	logic                        pend_set;
	logic                        lyc_fire;
	logic                        tick;
	logic                        finish;
	logic                        s_hs;

	assign s_hs     = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign tick     = (state_q == ST_RUN) && (ticks_q != 4'd0);
	assign finish   = (state_q == ST_RUN) && (ticks_q == 4'd0) &&
	                  (!out_valid_q || m_tready);
	assign line_inc = line_q + lmls_pkg::LINE_W'(1);

	always_comb begin
		mode_n   = mode_q;
		line_n   = line_q;
		line_chg = 1'b0;
		vbl_t    = 1'b0;
		stat_t   = 1'b0;
		drawn_t  = 1'b0;
		if (dres.mode_end) begin
			case (mode_q)
				lmls_pkg::MODE_HBLANK: begin
					line_n   = line_inc;
					line_chg = 1'b1;
					if (line_inc > lmls_pkg::LAST_DRAWN_LINE) begin
						mode_n = lmls_pkg::MODE_VBLANK;
						vbl_t  = 1'b1;
						stat_t = stat_en_q[lmls_pkg::STAT_VBLANK];
					end else begin
						mode_n = lmls_pkg::MODE_OAM;
						stat_t = stat_en_q[lmls_pkg::STAT_OAM];
					end
				end
				lmls_pkg::MODE_OAM: begin
					mode_n = lmls_pkg::MODE_DRAW;
				end
				lmls_pkg::MODE_DRAW: begin
					mode_n  = lmls_pkg::MODE_HBLANK;
					drawn_t = 1'b1;
					stat_t  = stat_en_q[lmls_pkg::STAT_HBLANK];
				end
				default: begin
					if (line_q == '0) begin
						mode_n = lmls_pkg::MODE_OAM;
						stat_t = stat_en_q[lmls_pkg::STAT_OAM];
					end else begin
						// line 153 reads as 0
						line_n   = (line_inc == lmls_pkg::VBLANK_WRAP_LINE) ? '0 : line_inc;
						line_chg = 1'b1;
					end
				end
			endcase
		end
	end

	assign pend_set = line_chg && (line_n == line_compare_q);
	assign lyc_fire = stat_en_q[lmls_pkg::STAT_LYC] && (pending_q || pend_set);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_enable_q   <= 1'b1;
			stat_en_q      <= '0;
			line_compare_q <= '0;
			double_speed_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				lmls_pkg::REG_LCD_ENABLE:   lcd_enable_q   <= cfg_wdata[0];
				lmls_pkg::REG_STAT_ENABLES: stat_en_q      <= cfg_wdata[3:0];
				lmls_pkg::REG_LINE_COMPARE: line_compare_q <= cfg_wdata;
				lmls_pkg::REG_DOUBLE_SPEED: double_speed_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= lmls_pkg::MODE_VBLANK;
			line_q      <= lmls_pkg::RESET_LINE;
			dots_q      <= lmls_pkg::RESET_DOTS;
			pending_q   <= 1'b0;
			ticks_q     <= '0;
			vbl_acc_q   <= 1'b0;
			stat_acc_q  <= 1'b0;
			drawn_acc_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_hs) begin
						ticks_q     <= s_tdata[5:2];
						vbl_acc_q   <= 1'b0;
						stat_acc_q  <= 1'b0;
						drawn_acc_q <= 1'b0;
						state_q     <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tick) begin
						ticks_q <= ticks_q - 4'd1;
						if (lcd_enable_q) begin
							dots_q      <= dres.dots;
							mode_q      <= mode_n;
							line_q      <= line_n;
							pending_q   <= (pending_q || pend_set) && !lyc_fire;
							vbl_acc_q   <= vbl_acc_q || vbl_t;
							stat_acc_q  <= stat_acc_q || stat_t || lyc_fire;
							drawn_acc_q <= drawn_acc_q || drawn_t;
						end
					end else if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= {3'b000, drawn_acc_q, stat_acc_q, vbl_acc_q, line_q, mode_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_RUN)
		else $error("accepted transaction did not start the sequencer");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> m_tvalid && state_q == ST_IDLE)
		else $error("finished transaction did not load the output register");

	a_vblank_line: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == lmls_pkg::MODE_VBLANK |->
		line_q == '0 || line_q > lmls_pkg::LAST_DRAWN_LINE)
		else $error("VBlank mode on a drawn line");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pending result lost or changed");
`endif

endmodule

// ===== hw/rtl/lmls_dot_unit.sv =====
// ----------------------------------------------------------------------------
// lmls_dot_unit
// Shared dot arithmetic: advance the dot counter by one tick, compare with the
// current mode length and take that length off when the mode ends.
// ----------------------------------------------------------------------------
module lmls_dot_unit (
	input  logic [lmls_pkg::DOT_W-1:0] dots,
	input  lmls_pkg::mode_t            mode,
	input  logic                       double_speed,
	output lmls_pkg::dot_res_t         res
);

	logic [lmls_pkg::DOT_W-1:0] base;
	logic [lmls_pkg::DOT_W-1:0] limit;
	logic [lmls_pkg::DOT_W-1:0] sum;

	always_comb begin
		case (mode)
			lmls_pkg::MODE_HBLANK: base = lmls_pkg::DOTS_HBLANK;
			lmls_pkg::MODE_OAM:    base = lmls_pkg::DOTS_OAM;
			lmls_pkg::MODE_DRAW:   base = lmls_pkg::DOTS_DRAW;
			default:               base = lmls_pkg::DOTS_VBLANK;
		endcase
	end

	// double speed: 912 still fits the counter
	assign limit = double_speed ? {base[lmls_pkg::DOT_W-2:0], 1'b0} : base;
	assign sum   = dots + lmls_pkg::DOT_W'(4);

	always_comb begin
		res.mode_end = (sum >= limit);
		res.dots     = res.mode_end ? (sum - limit) : sum;
	end

endmodule
